FILE: rtl/core/mcpg_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the midpoint circle pixel generator.
// No dependencies; imported by every module of the block.
package mcpg_pkg;

    localparam int DEFAULT_COORD_BITS  = 12;
    localparam int DEFAULT_RADIUS_BITS = 11;

    localparam int QUEUE_DEPTH = 2;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    localparam int          PIXEL_IDX_W = 3;
    localparam logic [PIXEL_IDX_W-1:0] PIXEL_FIRST = 3'd0;
    localparam logic [PIXEL_IDX_W-1:0] PIXEL_LAST  = 3'd7;

    localparam int DECISION_INC_EAST      = 3;
    localparam int DECISION_INC_SOUTHEAST = 5;

endpackage

FILE: rtl/core/midpoint_circle_pixel_generator.sv
`timescale 1ns / 1ps
// Midpoint circle pixel generator top level: front end, job queue, back end.
// Depends on mcpg_pkg, mcpg_front, mcpg_queue and mcpg_back.
//
// A start item (func 0) loads the centre and radius and emits nothing. Each
// step item (func 1) of a live circle emits eight pixels, one per cycle on the
// output port while out_stall is low; that port is what sets the rate. The
// front end takes an item every cycle while the two-entry job queue has room,
// so starts and dead steps never enter the queue. The eighth pixel of each
// step carries last_of_step, and of the final step circle_done as well. A step
// passes through the queue entry, the back-end job registers and the output
// register before its first pixel appears.
module midpoint_circle_pixel_generator
    import mcpg_pkg::*;
#(
    parameter int COORD_BITS  = DEFAULT_COORD_BITS,
    parameter int RADIUS_BITS = DEFAULT_RADIUS_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  logic [COORD_BITS-1:0]        center_x,
    input  logic [COORD_BITS-1:0]        center_y,
    input  logic [RADIUS_BITS-1:0]       radius,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS+1:0] pixel_x,
    output logic signed [COORD_BITS+1:0] pixel_y,
    output logic                         last_of_step,
    output logic                         circle_done
);

    localparam int JOB_W = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

    logic                   q_full;
    logic                   q_empty;
    logic                   q_push;
    logic                   q_pop;
    logic [JOB_W-1:0]       push_job;
    logic [JOB_W-1:0]       pop_job;

    logic [COORD_BITS-1:0]  f_cx;
    logic [COORD_BITS-1:0]  f_cy;
    logic [RADIUS_BITS-1:0] f_x;
    logic [RADIUS_BITS-1:0] f_y;
    logic                   f_done;

    logic [COORD_BITS-1:0]  b_cx;
    logic [COORD_BITS-1:0]  b_cy;
    logic [RADIUS_BITS-1:0] b_x;
    logic [RADIUS_BITS-1:0] b_y;
    logic                   b_done;

    mcpg_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cx     (f_cx),
        .q_cy     (f_cy),
        .q_x      (f_x),
        .q_y      (f_y),
        .q_done   (f_done)
    );

    assign push_job = {f_cx, f_cy, f_x, f_y, f_done};

    mcpg_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_job),
        .empty     (q_empty)
    );

    assign {b_cx, b_cy, b_x, b_y, b_done} = pop_job;

    mcpg_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_cx         (b_cx),
        .q_cy         (b_cy),
        .q_x          (b_x),
        .q_y          (b_y),
        .q_done       (b_done),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

`ifndef SYNTHESIS
    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && circle_done) |-> last_of_step)
        else $error("circle_done without last_of_step");

    a_step_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_of_step) |=> (!out_valid || !last_of_step))
        else $error("two step ends back to back");

    a_step_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_step) |=> out_valid)
        else $error("gap inside a step");
`endif

endmodule

FILE: rtl/core/mcpg_front.sv
`timescale 1ns / 1ps
// Front end: accepts start and step items, keeps the octant point and decision
// value, and queues one job per live step. Uses mcpg_pkg.
module mcpg_front
    import mcpg_pkg::*;
#(
    parameter int COORD_BITS  = DEFAULT_COORD_BITS,
    parameter int RADIUS_BITS = DEFAULT_RADIUS_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   func,
    input  logic [COORD_BITS-1:0]  center_x,
    input  logic [COORD_BITS-1:0]  center_y,
    input  logic [RADIUS_BITS-1:0] radius,
    input  logic                   q_full,
    output logic                   q_push,
    output logic [COORD_BITS-1:0]  q_cx,
    output logic [COORD_BITS-1:0]  q_cy,
    output logic [RADIUS_BITS-1:0] q_x,
    output logic [RADIUS_BITS-1:0] q_y,
    output logic                   q_done
);

    localparam int XW = RADIUS_BITS + 1;
    localparam int CW = RADIUS_BITS + 2;
    localparam int DW = RADIUS_BITS + 5;

    logic [COORD_BITS-1:0]  cx_reg;
    logic [COORD_BITS-1:0]  cy_reg;
    logic [XW-1:0]          x_reg;
    logic [RADIUS_BITS-1:0] y_reg;
    logic signed [DW-1:0]   d_reg;
    logic                   active_reg;

    logic                   accept;
    logic                   step_live;
    logic                   d_neg;
    logic signed [DW-1:0]   x_s;
    logic signed [DW-1:0]   y_s;
    logic signed [DW-1:0]   d_next;
    logic signed [CW-1:0]   ny_s;
    logic [XW-1:0]          x_next;
    logic [RADIUS_BITS-1:0] y_next;
    logic                   done;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign step_live = active_reg && (x_reg <= XW'(y_reg));

    assign d_neg = d_reg[DW-1];
    assign x_s   = $signed(DW'(x_reg));
    assign y_s   = $signed(DW'(y_reg));

    always_comb
    begin
        if (d_neg)
        begin
            d_next = d_reg + (x_s <<< 1) + $signed(DW'(DECISION_INC_EAST));
            ny_s   = $signed(CW'(y_reg));
        end
        else
        begin
            d_next = d_reg + ((x_s - y_s) <<< 1) + $signed(DW'(DECISION_INC_SOUTHEAST));
            ny_s   = $signed(CW'(y_reg)) - $signed(CW'(1));
        end
    end

    assign x_next = x_reg + XW'(1);
    assign done   = $signed(CW'(x_next)) > ny_s;
    assign y_next = ny_s[CW-1] ? '0 : ny_s[RADIUS_BITS-1:0];

    assign q_push = accept && (func == FUNC_STEP) && step_live;
    assign q_cx   = cx_reg;
    assign q_cy   = cy_reg;
    assign q_x    = x_reg[RADIUS_BITS-1:0];
    assign q_y    = y_reg;
    assign q_done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            d_reg      <= '0;
            active_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (func == FUNC_START)
            begin
                cx_reg     <= center_x;
                cy_reg     <= center_y;
                x_reg      <= '0;
                y_reg      <= radius;
                d_reg      <= $signed(DW'(1)) - $signed(DW'(radius));
                active_reg <= 1'b1;
            end
            else if (step_live)
            begin
                x_reg      <= x_next;
                y_reg      <= y_next;
                d_reg      <= d_next;
                active_reg <= !done;
            end
            else
            begin
                active_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/mcpg_queue.sv
`timescale 1ns / 1ps
// Short job queue between front and back end, held in flip-flops.
// Uses QUEUE_DEPTH from mcpg_pkg.
module mcpg_queue
    import mcpg_pkg::*;
#(
    parameter int WIDTH = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full     = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/core/mcpg_back.sv
`timescale 1ns / 1ps
// Back end: takes one job from the queue and emits its eight symmetric pixels,
// one per cycle when not stalled, via an output register. Uses mcpg_pkg.
module mcpg_back
    import mcpg_pkg::*;
#(
    parameter int COORD_BITS  = DEFAULT_COORD_BITS,
    parameter int RADIUS_BITS = DEFAULT_RADIUS_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  logic [COORD_BITS-1:0]        q_cx,
    input  logic [COORD_BITS-1:0]        q_cy,
    input  logic [RADIUS_BITS-1:0]       q_x,
    input  logic [RADIUS_BITS-1:0]       q_y,
    input  logic                         q_done,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS+1:0] pixel_x,
    output logic signed [COORD_BITS+1:0] pixel_y,
    output logic                         last_of_step,
    output logic                         circle_done
);

    localparam int PW = COORD_BITS + 2;

    logic                   busy_reg;
    logic [PIXEL_IDX_W-1:0] idx_reg;
    logic [COORD_BITS-1:0]  cx_reg;
    logic [COORD_BITS-1:0]  cy_reg;
    logic [RADIUS_BITS-1:0] x_reg;
    logic [RADIUS_BITS-1:0] y_reg;
    logic                   done_reg;

    logic                   out_valid_reg;
    logic [PW-1:0]          pixel_x_reg;
    logic [PW-1:0]          pixel_y_reg;
    logic                   last_reg;
    logic                   circle_done_reg;

    logic                   advance;
    logic                   is_last;
    logic [RADIUS_BITS-1:0] off_a;
    logic [RADIUS_BITS-1:0] off_b;
    logic [PW-1:0]          px_next;
    logic [PW-1:0]          py_next;

    assign advance = busy_reg && (!out_valid_reg || !out_stall);
    assign is_last = idx_reg == PIXEL_LAST;
    assign q_pop   = !q_empty && (!busy_reg || (advance && is_last));

    // index bit 2 swaps x and y, bit 0 negates the x offset, bit 1 the y offset
    assign off_a   = idx_reg[2] ? y_reg : x_reg;
    assign off_b   = idx_reg[2] ? x_reg : y_reg;
    assign px_next = idx_reg[0] ? PW'(cx_reg) - PW'(off_a) : PW'(cx_reg) + PW'(off_a);
    assign py_next = idx_reg[1] ? PW'(cy_reg) - PW'(off_b) : PW'(cy_reg) + PW'(off_b);

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cx_reg   <= q_cx;
            cy_reg   <= q_cy;
            x_reg    <= q_x;
            y_reg    <= q_y;
            done_reg <= q_done;
        end
        if (advance)
        begin
            pixel_x_reg     <= px_next;
            pixel_y_reg     <= py_next;
            last_reg        <= is_last;
            circle_done_reg <= is_last && done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= PIXEL_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= PIXEL_FIRST;
            end
            else if (advance)
            begin
                busy_reg <= !is_last;
                idx_reg  <= idx_reg + PIXEL_IDX_W'(1);
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = $signed(pixel_x_reg);
    assign pixel_y      = $signed(pixel_y_reg);
    assign last_of_step = last_reg;
    assign circle_done  = circle_done_reg;

endmodule
